FILE: sv/lkt_pkg.sv
// Shared constants and types for the LRU key tracker.
package lkt_pkg;

    localparam int ENTRIES = 8;
    localparam int KEY_W   = 32;
    localparam int CAP_W   = 4;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [OCC_W-1:0]  occ_t;

    typedef struct packed {
        logic hit;
        occ_t occupancy;
    } lkt_stat_t;

endpackage

FILE: sv/lkt_ifs.sv
// Valid/ready channel interfaces for accesses, results and the capacity register.
interface lkt_access_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] key;

    modport source (output valid, output key, input ready);
    modport sink (input valid, input key, output ready);
endinterface

interface lkt_result_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, output hit, input ready);
    modport sink (input valid, input hit, output ready);
endinterface

interface lkt_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink (input valid, input capacity, output ready);
endinterface

FILE: sv/lkt_core.sv
// Key store, recency ranks and the combinational lookup and registered rank update.
module lkt_core
    import lkt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CAP_W-1:0] capacity,
    input  logic             advance,
    input  logic [KEY_W-1:0] key,
    output lkt_stat_t        stat
);

    logic [KEY_W-1:0] keys_reg [ENTRIES];
    rank_t            ranks_reg [ENTRIES];
    occ_t             occ_reg;
    occ_t             occ_next;

    logic [ENTRIES-1:0] valid;
    logic               found;
    idx_t               hit_idx;
    idx_t               lru_idx;
    idx_t               target;
    occ_t               eff_cap;
    occ_t               limit;
    logic               room;
    logic [ENTRIES-1:0] age;

    always_comb
    begin
        if (capacity == '0)
        begin
            eff_cap = occ_t'(1);
        end
        else if (int'(capacity) > ENTRIES)
        begin
            eff_cap = occ_t'(ENTRIES);
        end
        else
        begin
            eff_cap = occ_t'(capacity);
        end
    end

    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        lru_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            valid[i] = (occ_t'(i) < occ_reg);
            if (valid[i] && keys_reg[i] == key)
            begin
                found   = 1'b1;
                hit_idx = idx_t'(i);
            end
            if (valid[i] && ranks_reg[i] == rank_t'(occ_reg - occ_t'(1)))
            begin
                lru_idx = idx_t'(i);
            end
        end
    end

    assign room = (occ_reg < eff_cap);

    always_comb
    begin
        if (found)
        begin
            limit  = occ_t'(ranks_reg[hit_idx]);
            target = hit_idx;
        end
        else if (room)
        begin
            limit  = occ_reg;
            target = idx_t'(occ_reg);
        end
        else
        begin
            limit  = occ_reg - occ_t'(1);
            target = lru_idx;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            age[i] = valid[i] && (occ_t'(ranks_reg[i]) < limit);
        end
    end

    assign occ_next = (!found && room) ? occ_reg + occ_t'(1) : occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (advance)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (idx_t'(i) == target)
                begin
                    ranks_reg[i] <= '0;
                    if (!found)
                    begin
                        keys_reg[i] <= key;
                    end
                end
                else if (age[i])
                begin
                    ranks_reg[i] <= ranks_reg[i] + rank_t'(1);
                end
            end
        end
    end

    assign stat.hit       = found;
    assign stat.occupancy = occ_reg;

endmodule

FILE: sv/lru_key_tracker.sv
// Top level of the LRU key tracker: request and result registers around the core.
// The tracker takes one access request per clock while the result channel is not
// stalled and returns its hit flag from the result register: the request is
// registered, then the parallel key compare and recency-rank update of all
// entries complete as the result register loads. A stalled result holds one
// more request in the input register before the access channel stops taking
// requests. The capacity register is always writable and should be changed
// only while no request is in flight.
module lru_key_tracker
    import lkt_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    lkt_access_if.sink   access,
    lkt_result_if.source result,
    lkt_cfg_if.sink      cfg
);

    logic             req_valid_reg;
    logic [KEY_W-1:0] req_key_reg;
    logic             res_valid_reg;
    logic             res_hit_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic             advance;
    lkt_stat_t        stat;

    assign advance      = req_valid_reg && (!res_valid_reg || result.ready);
    assign access.ready = !req_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign result.valid = res_valid_reg;
    assign result.hit   = res_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            capacity_reg  <= CAP_RESET;
        end
        else
        begin
            if (access.ready)
            begin
                req_valid_reg <= access.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                capacity_reg <= cfg.capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (access.valid && access.ready)
        begin
            req_key_reg <= access.key;
        end
        if (advance)
        begin
            res_hit_reg <= stat.hit;
        end
    end

    lkt_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (capacity_reg),
        .advance  (advance),
        .key      (req_key_reg),
        .stat     (stat)
    );

    // The occupancy never exceeds the built depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(stat.occupancy) <= ENTRIES)
        else $error("occupancy above the built depth");

    // The occupancy changes only when a request is processed, and then by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(stat.occupancy))
        else $error("occupancy changed without a request");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (stat.occupancy == $past(stat.occupancy)
                  || stat.occupancy == $past(stat.occupancy) + occ_t'(1)))
        else $error("occupancy moved by more than one");

    // A hit needs at least one held entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stat.hit |-> stat.occupancy != '0)
        else $error("hit reported with an empty tracker");

endmodule
